// ===== rtl/tilt_compensated_compass_heading_core_macros.svh =====
// Assertion macros shared by the compass heading checker.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_CORE_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_CORE_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define TCH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// Checks that an implication holds in the cycle after the antecedent.
`define TCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/tcch_pkg.sv =====
// Types, constants and functions shared by the compass heading blocks.
package tcch_pkg;

  localparam int unsigned AngleQ = 16;
  localparam int unsigned TableLen = 24;
  localparam int unsigned AngleW = 28;
  localparam logic [6:0] OneGReset = 7'd56;
  localparam logic [8:0] FullTurn = 9'd360;

  typedef struct packed {
    logic signed [7:0]  accel_x;
    logic signed [7:0]  accel_y;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } in_item_t;

  typedef struct packed {
    logic [8:0] heading_deg;
    logic       tilt_clamped;
  } out_item_t;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic [AngleW-1:0] atan_lut(input logic [4:0] idx);
    logic [AngleW-1:0] r;
    case (idx)
      5'd0:  r = 28'd2949120;
      5'd1:  r = 28'd1740967;
      5'd2:  r = 28'd919879;
      5'd3:  r = 28'd466945;
      5'd4:  r = 28'd234379;
      5'd5:  r = 28'd117304;
      5'd6:  r = 28'd58666;
      5'd7:  r = 28'd29335;
      5'd8:  r = 28'd14668;
      5'd9:  r = 28'd7334;
      5'd10: r = 28'd3667;
      5'd11: r = 28'd1833;
      5'd12: r = 28'd917;
      5'd13: r = 28'd458;
      5'd14: r = 28'd229;
      5'd15: r = 28'd115;
      5'd16: r = 28'd57;
      5'd17: r = 28'd29;
      5'd18: r = 28'd14;
      5'd19: r = 28'd7;
      5'd20: r = 28'd4;
      5'd21: r = 28'd2;
      5'd22: r = 28'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tilt_compensated_compass_heading_core.sv =====
// Top level of the pipelined tilt-compensated compass heading core.
//   channel  | signals                              | transfer when
//   in       | in_valid_i, in_ready_o, in_data_i    | in_valid_i && in_ready_o
//   out      | out_valid_o, out_ready_i, out_data_o | out_valid_o && out_ready_i
//   config   | cfg_we_i, cfg_wdata_i                | cfg_we_i
// One sample enters per cycle while the pipeline advances. The stages are FRACTION_BITS
// divider cells, FRACTION_BITS+1 root cells, 5 product stages, CORDIC_STAGES rotation
// cells (at most 24) and 1 output register.
// The whole pipeline advances only when its output register is empty or being drained,
// so a stalled output also stalls the input.
// Reset clears the valid bits and loads one_g_q with 56.
module tilt_compensated_compass_heading_core #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcch_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcch_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i
);
  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned NC = (CORDIC_STAGES < tcch_pkg::TableLen) ?
                               CORDIC_STAGES : tcch_pkg::TableLen;
  localparam int unsigned QW = F + 1;          // sine magnitude
  localparam int unsigned VW = 2 * F + 2;      // root operand
  localparam int unsigned PW = 2 * F + 2;      // sine products
  localparam int unsigned XW = F + 22;         // horizontal components
  localparam int unsigned ND = F;              // divider cells
  localparam int unsigned NS = F + 1;          // root cells
  localparam int unsigned NP = 5;              // product stages
  localparam int unsigned LAT = ND + NS + NP + NC;
  localparam logic [QW-1:0] One = QW'(1) << F;

  typedef struct packed {
    logic [QW-1:0] sp;
    logic          np;
    logic [QW-1:0] sr;
    logic          nr;
    logic          clamp;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
  } side_t;

  logic [6:0] one_g_q;
  logic [LAT-1:0] vld_q;
  logic out_valid_q;
  tcch_pkg::out_item_t out_q;
  logic adv;

  assign adv = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_g_q <= tcch_pkg::OneGReset;
    end else if (cfg_we_i) begin
      one_g_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  // Input conditioning: magnitudes, clamp test and saturated-sine flags.
  logic [6:0] g;
  logic [7:0] max, may;
  logic satx, saty;
  side_t side_in;
  assign g = (one_g_q == 7'd0) ? 7'd1 : one_g_q;
  assign max = in_data_i.accel_x[7] ? 8'(-in_data_i.accel_x) : 8'(in_data_i.accel_x);
  assign may = in_data_i.accel_y[7] ? 8'(-in_data_i.accel_y) : 8'(in_data_i.accel_y);
  assign satx = max >= {1'b0, g};
  assign saty = may >= {1'b0, g};
  always_comb begin
    side_in.sp = satx ? One : '0;
    side_in.np = in_data_i.accel_x[7];
    side_in.sr = saty ? One : '0;
    side_in.nr = in_data_i.accel_y[7];
    side_in.clamp = (max > {1'b0, g}) || (may > {1'b0, g});
    side_in.mx = in_data_i.mag_x;
    side_in.my = in_data_i.mag_y;
    side_in.mz = in_data_i.mag_z;
  end

  // Divider chain: two lanes of restoring cells, quotient bits MSB first.
  // With |a| < g the remainder starts at |a| and F steps give |a|*2^F/g.
  // A saturated sine starts from zero so its quotient stays zero.
  logic [7:0] rx [ND+1];
  logic [7:0] ry [ND+1];
  logic [QW-1:0] qx [ND+1];
  logic [QW-1:0] qy [ND+1];
  logic [6:0] dx [ND+1];
  logic [6:0] dy [ND+1];
  side_t sd [ND+1];
  assign rx[0] = satx ? 8'd0 : max;
  assign ry[0] = saty ? 8'd0 : may;
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign dx[0] = g;
  assign dy[0] = g;
  assign sd[0] = side_in;

  for (genvar i = 0; i < ND; i++) begin : g_div
    side_t sd_q;
    tcch_div_cell #(.QW(QW)) u_dx (
      .clk_i(clk_i), .en_i(adv), .rem_i(rx[i]), .quo_i(qx[i]),
      .den_i(dx[i]), .rem_o(rx[i+1]), .quo_o(qx[i+1]), .den_o(dx[i+1]));
    tcch_div_cell #(.QW(QW)) u_dy (
      .clk_i(clk_i), .en_i(adv), .rem_i(ry[i]), .quo_i(qy[i]),
      .den_i(dy[i]), .rem_o(ry[i+1]), .quo_o(qy[i+1]), .den_o(dy[i+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q <= sd[i];
      end
    end
    assign sd[i+1] = sd_q;
  end

  // Root operands.
  logic [QW-1:0] sp_m, sr_m;
  assign sp_m = sd[ND].sp | qx[ND];
  assign sr_m = sd[ND].sr | qy[ND];

  logic [VW-1:0] vp [NS+1];
  logic [VW-1:0] vr [NS+1];
  logic [VW-1:0] pr [NS+1];
  logic [VW-1:0] rr [NS+1];
  logic [QW-1:0] spk [NS+1];
  logic [QW-1:0] srk [NS+1];
  side_t ss [NS+1];
  always_comb begin
    vp[0] = (VW'(1) << (2 * F)) - VW'(sp_m) * VW'(sp_m);
    vr[0] = (VW'(1) << (2 * F)) - VW'(sr_m) * VW'(sr_m);
  end
  assign pr[0] = '0;
  assign rr[0] = '0;
  assign spk[0] = sp_m;
  assign srk[0] = sr_m;
  assign ss[0] = sd[ND];

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    logic [QW-1:0] spk_q, srk_q;
    side_t ss_q;
    tcch_sqrt_cell #(.VW(VW), .BITPOS(F - i)) u_sp (
      .clk_i(clk_i), .en_i(adv), .val_i(vp[i]), .res_i(pr[i]),
      .val_o(vp[i+1]), .res_o(pr[i+1]));
    tcch_sqrt_cell #(.VW(VW), .BITPOS(F - i)) u_sr (
      .clk_i(clk_i), .en_i(adv), .val_i(vr[i]), .res_i(rr[i]),
      .val_o(vr[i+1]), .res_o(rr[i+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        spk_q <= spk[i];
        srk_q <= srk[i];
        ss_q <= ss[i];
      end
    end
    assign spk[i+1] = spk_q;
    assign srk[i+1] = srk_q;
    assign ss[i+1] = ss_q;
  end

  // Product stages.
  logic [QW-1:0] cp1, cr1;
  assign cp1 = QW'(pr[NS]);
  assign cr1 = QW'(rr[NS]);

  // Stage 1: sine products, magnitudes with sign tracking.
  logic [QW-1:0] p1_sp, p1_cp, p1_cr, p1_ss, p1_sc;
  logic p1_np, p1_nr;
  side_t p1_s;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_sp <= spk[NS];
      p1_cp <= cp1;
      p1_cr <= cr1;
      p1_ss <= QW'((PW'(srk[NS]) * PW'(spk[NS])) >> F);
      p1_sc <= QW'((PW'(srk[NS]) * PW'(cp1)) >> F);
      p1_np <= ss[NS].np;
      p1_nr <= ss[NS].nr;
      p1_s <= ss[NS];
    end
  end

  // Stage 2: signed Q(F) coefficients.
  logic signed [QW:0] c_sp, c_cp, c_cr, c_ss, c_sc;
  side_t p2_s;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sp <= p1_np ? -$signed({1'b0, p1_sp}) : $signed({1'b0, p1_sp});
      c_cp <= $signed({1'b0, p1_cp});
      c_cr <= $signed({1'b0, p1_cr});
      c_ss <= (p1_np ^ p1_nr) ? -$signed({1'b0, p1_ss}) : $signed({1'b0, p1_ss});
      c_sc <= p1_nr ? -$signed({1'b0, p1_sc}) : $signed({1'b0, p1_sc});
      p2_s <= p1_s;
    end
  end

  // Stage 3: five products of a field by a coefficient.
  logic signed [XW-1:0] m1, m2, m3, m4, m5;
  side_t p3_s;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1 <= XW'(p2_s.mx * c_cp);
      m2 <= XW'(p2_s.mz * c_sp);
      m3 <= XW'(p2_s.mx * c_ss);
      m4 <= XW'(p2_s.my * c_cr);
      m5 <= XW'(p2_s.mz * c_sc);
      p3_s <= p2_s;
    end
  end

  // Stage 4: sums.
  logic signed [XW-1:0] xh, yh;
  logic p4_c;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xh <= m1 + m2;
      yh <= m3 + m4 - m5;
      p4_c <= p3_s.clamp;
    end
  end

  // Stage 5: quadrant fold and special-case codes.
  logic signed [XW-1:0] cx [NC+1];
  logic signed [XW-1:0] cy [NC+1];
  logic signed [tcch_pkg::AngleW-1:0] cz [NC+1];
  logic [1:0] sc [NC+1];
  logic [8:0] sv [NC+1];
  logic cc [NC+1];
  localparam logic signed [tcch_pkg::AngleW-1:0] Half = 28'sd180 <<< tcch_pkg::AngleQ;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx[0] <= (xh < 0) ? -xh : xh;
      cy[0] <= (xh < 0) ? -yh : yh;
      cz[0] <= (xh < 0) ? ((yh > 0) ? Half : -Half) : '0;
      cc[0] <= p4_c;
      if (yh == 0) begin
        sc[0] <= 2'd1;
        sv[0] <= (xh < 0) ? 9'd180 : 9'd0;
      end else if (xh == 0) begin
        sc[0] <= 2'd1;
        sv[0] <= (yh > 0) ? 9'd90 : 9'd270;
      end else begin
        sc[0] <= 2'd0;
        sv[0] <= 9'd0;
      end
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic [1:0] sc_q;
    logic [8:0] sv_q;
    logic cc_q;
    tcch_cordic_cell #(.XW(XW), .STAGE(i)) u_c (
      .clk_i(clk_i), .en_i(adv), .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]),
      .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sc_q <= sc[i];
        sv_q <= sv[i];
        cc_q <= cc[i];
      end
    end
    assign sc[i+1] = sc_q;
    assign sv[i+1] = sv_q;
    assign cc[i+1] = cc_q;
  end

  // Output: truncate toward zero to whole degrees and wrap.
  logic signed [tcch_pkg::AngleW-1:0] zf, zmag;
  logic signed [10:0] deg;
  logic [8:0] head;
  always_comb begin
    zf = cz[NC];
    zmag = (zf < 0) ? -zf : zf;
    deg = 11'(zmag >>> tcch_pkg::AngleQ);
    if (zf < 0) deg = -deg;
    if (deg < 0) deg = deg + 11'sd360;
    if (deg >= 11'sd360) deg = deg - 11'sd360;
    if (deg < 0) deg = '0;
    head = (sc[NC] != 2'd0) ? sv[NC] : 9'(deg);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.heading_deg <= (head >= tcch_pkg::FullTurn) ? 9'd0 : head;
      out_q.tilt_clamped <= cc[NC];
    end
  end
endmodule

// ===== rtl/tcch_div_cell.sv =====
// One restoring-division step cell that forms one quotient bit of a tilt sine.
module tcch_div_cell #(
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [7:0]    rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [6:0]    den_i,
  output logic [7:0]    rem_o,
  output logic [QW-1:0] quo_o,
  output logic [6:0]    den_o
);
  logic [8:0] trial;
  logic [7:0] rem_d, rem_q;
  logic [QW-1:0] quo_d, quo_q;
  logic [6:0] den_q;

  always_comb begin
    trial = {rem_i, 1'b0} - {2'b00, den_i};
    if (!trial[8]) begin
      rem_d = trial[7:0];
      quo_d = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_d = {rem_i[6:0], 1'b0};
      quo_d = {quo_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;
endmodule

// ===== rtl/tcch_sqrt_cell.sv =====
// One digit-recurrence square root cell that settles one result bit.
module tcch_sqrt_cell #(
  parameter int unsigned VW = 34,
  parameter int unsigned BITPOS = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] val_i,
  input  logic [VW-1:0] res_i,
  output logic [VW-1:0] val_o,
  output logic [VW-1:0] res_o
);
  localparam logic [VW-1:0] Bit = VW'(1) << (2 * BITPOS);
  logic [VW-1:0] val_d, val_q, res_d, res_q;

  always_comb begin
    if (val_i >= res_i + Bit) begin
      val_d = val_i - (res_i + Bit);
      res_d = (res_i >> 1) + Bit;
    end else begin
      val_d = val_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      res_q <= res_d;
    end
  end

  assign val_o = val_q;
  assign res_o = res_q;
endmodule

// ===== rtl/tcch_cordic_cell.sv =====
// One vectoring CORDIC rotation cell with its fixed shift and angle step.
module tcch_cordic_cell #(
  parameter int unsigned XW = 72,
  parameter int unsigned STAGE = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [XW-1:0]        x_i,
  input  logic signed [XW-1:0]        y_i,
  input  logic signed [tcch_pkg::AngleW-1:0] z_i,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output logic signed [tcch_pkg::AngleW-1:0] z_o
);
  localparam logic [tcch_pkg::AngleW-1:0] Step = tcch_pkg::atan_lut(5'(STAGE));
  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [tcch_pkg::AngleW-1:0] z_d, z_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + $signed(Step);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - $signed(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// ===== rtl/tcch_checker.sv =====
// Port-level checker for the compass heading core, with its bind.
`include "tilt_compensated_compass_heading_core_macros.svh"
module tcch_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcch_pkg::out_item_t out_data_o
);
  `TCH_ASSERT_IMPL(a_heading_range, clk_i, rst_ni, out_valid_o, out_data_o.heading_deg < 9'd360)
  `TCH_ASSERT_IMPL(a_ready_when_drain, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
  `TCH_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
endmodule

bind tilt_compensated_compass_heading_core tcch_checker u_tcch_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o));
